// ----- hdl/sem_pkg.sv -----
package sem_pkg;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int CFG_W        = 13;
	localparam int FW_W         = 11;
	localparam int FH_W         = 13;
	localparam int HEIGHT_LIMIT = 4096;

	// gx^2 + gy^2 fits in 21 bits
	localparam int SUM_W = 21;
	localparam int GRAD_W = 11;
	localparam logic [7:0] SAT_MAX = 8'd255;
	// above 255*255+255 the rounded root is at least 256
	localparam logic [SUM_W-1:0] SAT_SUM = 21'd65280;

	typedef logic [23:0] pix_t;
	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_SUM,
		S_SQ,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_OUT
	} state_t;

endpackage

// ----- hdl/sobel_edge_magnitude_rgb.sv -----
// Streaming 3x3 Sobel edge magnitude on RGB pixels sent in raster order. Each colour
// channel is filtered on its own and gives round(sqrt(gx^2 + gy^2)) saturated to 255,
// with pixels outside the frame taken as zero. The result for a pixel leaves on the
// transfer that arrives frame_width+1 places later, so after the frame's pixels the
// source sends frame_width+1 flush items; frame_end marks the frame's last result,
// after which the block starts a new frame. A flush item while pixels are still due
// is dropped; once all pixels are in, every item drains whatever its action. Writing
// either register restarts the frame. Items are handled one at a time: an item that
// yields a result passes the read, sum, square and root states, the root an eight-step
// bit-serial square root run on the three channels side by side, and waits while the
// output stalls; one near the frame top that yields nothing ends after the read. The two
// previous rows sit in one synchronous line memory, read and written back per column;
// it needs no clearing after reset, as rows above the frame are masked out.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [7:0]                in_red,
	input  logic [7:0]                in_green,
	input  logic [7:0]                in_blue,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_red,
	output logic [7:0]                out_green,
	output logic [7:0]                out_blue,
	output logic                      frame_end
);
	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// configuration
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [WW-1:0]   eff_w;
	logic [FH_W-1:0] eff_h;

	// frame position
	logic [CW-1:0]   col_q;
	logic [FH_W-1:0] row_q;
	logic            pix_done_q;

	state_t state_q, state_d;

	// line memory: {two rows up, one row up} per column
	logic [47:0] line_mem [MAX_WIDTH];
	logic [47:0] rd_q;
	logic        mem_we;

	pix_t win_q [3][3];
	pix_t pix_s1;
	pix_t sel_s1 [3][3];
	logic fe_s1;
	grad_t gx_s2 [3];
	grad_t gy_s2 [3];
	logic  fe_s2;
	sum_t  sq_s3 [3];
	logic  fe_s3;

	logic       root_start;
	logic [2:0] root_done;
	logic [7:0] root_mag [3];
	logic       out_load;

	logic       out_valid_q;
	logic [7:0] out_red_q, out_green_q, out_blue_q;
	logic       frame_end_q;

	logic accept;
	assign accept = in_valid && !in_stall;

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = FH_W'(1);
		end else if (32'(frame_height_q) > HEIGHT_LIMIT) begin
			eff_h = FH_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = frame_height_q;
		end
	end

	// position arithmetic of the item being processed
	logic [WW:0]     col_next;
	logic            last_col;
	logic            emit;
	logic [FH_W-1:0] res_row;
	logic [CW-1:0]   res_col;
	logic            top_edge, bot_edge, left_edge, right_edge;
	logic            fe_now;
	logic            pix_last;
	pix_t            new_col [3];
	pix_t            sel_d [3][3];

	always_comb begin
		col_next = (WW+1)'(col_q) + (WW+1)'(1);
		last_col = col_next >= (WW+1)'(eff_w);
		emit     = (row_q >= FH_W'(2)) || (row_q == FH_W'(1) && col_q != '0);
		if (col_q != '0) begin
			res_row = row_q - FH_W'(1);
			res_col = col_q - CW'(1);
		end else begin
			res_row = row_q - FH_W'(2);
			res_col = CW'(eff_w - WW'(1));
		end
		top_edge   = res_row == '0;
		bot_edge   = (14'(res_row) + 14'd1) >= 14'(eff_h);
		left_edge  = res_col == '0;
		right_edge = ((WW+1)'(res_col) + (WW+1)'(1)) >= (WW+1)'(eff_w);
		fe_now     = emit && (res_row == eff_h - FH_W'(1))
			&& (((WW+1)'(res_col) + (WW+1)'(1)) == (WW+1)'(eff_w));
		pix_last   = !pix_done_q && (row_q == eff_h - FH_W'(1)) && last_col;

		new_col[0] = rd_q[47:24];
		new_col[1] = rd_q[23:0];
		new_col[2] = pix_s1;
		for (int j = 0; j < 3; j++) begin
			sel_d[0][j] = win_q[1][j];
			sel_d[1][j] = win_q[2][j];
			sel_d[2][j] = (col_q == '0) ? '0 : new_col[j];
		end
		for (int i = 0; i < 3; i++) begin
			if (top_edge) sel_d[i][0] = '0;
			if (bot_edge) sel_d[i][2] = '0;
		end
		for (int j = 0; j < 3; j++) begin
			if (left_edge)  sel_d[0][j] = '0;
			if (right_edge) sel_d[2][j] = '0;
		end
	end

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		root_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// a flush while pixels are still due is dropped
				if (in_valid && !(action && !pix_done_q)) state_d = S_RD;
			end
			S_RD: begin
				mem_we  = 1'b1;
				state_d = emit ? S_SUM : S_IDLE;
			end
			S_SUM:     state_d = S_SQ;
			S_SQ:      state_d = S_ROOT_GO;
			S_ROOT_GO: begin
				root_start = 1'b1;
				state_d    = S_ROOT_WAIT;
			end
			S_ROOT_WAIT: begin
				if (root_done[0]) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// registers, frame position and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(1024);
			frame_height_q <= FH_W'(1024);
			col_q          <= '0;
			row_q          <= '0;
			pix_done_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
					default: ;
				endcase
				col_q      <= '0;
				row_q      <= '0;
				pix_done_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[i][j] <= '0;
					end
				end
			end else if (state_q == S_RD) begin
				if (fe_now) begin
					// frame complete: back to the start
					col_q      <= '0;
					row_q      <= '0;
					pix_done_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						for (int j = 0; j < 3; j++) begin
							win_q[i][j] <= '0;
						end
					end
				end else begin
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + FH_W'(1);
					end else begin
						col_q <= CW'(col_next);
					end
					if (pix_last) pix_done_q <= 1'b1;
					for (int j = 0; j < 3; j++) begin
						win_q[0][j] <= win_q[1][j];
						win_q[1][j] <= win_q[2][j];
						win_q[2][j] <= new_col[j];
					end
				end
			end
		end
	end

	// line memory, read every cycle at the current column
	always_ff @(posedge clk) begin
		rd_q <= line_mem[col_q];
		if (mem_we) begin
			line_mem[col_q] <= {rd_q[23:0], pix_s1};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			// during drain the colour is ignored
			pix_s1 <= pix_done_q ? '0 : {in_red, in_green, in_blue};
		end
		if (state_q == S_RD) begin
			sel_s1 <= sel_d;
			fe_s1  <= fe_now;
		end
		if (state_q == S_SUM) begin
			for (int k = 0; k < 3; k++) begin
				gx_s2[k] <= (grad_t'(sel_s1[2][0][8*k +: 8]) + (grad_t'(sel_s1[2][1][8*k +: 8]) <<< 1)
					+ grad_t'(sel_s1[2][2][8*k +: 8]))
					- (grad_t'(sel_s1[0][0][8*k +: 8]) + (grad_t'(sel_s1[0][1][8*k +: 8]) <<< 1)
					+ grad_t'(sel_s1[0][2][8*k +: 8]));
				gy_s2[k] <= (grad_t'(sel_s1[0][2][8*k +: 8]) + (grad_t'(sel_s1[1][2][8*k +: 8]) <<< 1)
					+ grad_t'(sel_s1[2][2][8*k +: 8]))
					- (grad_t'(sel_s1[0][0][8*k +: 8]) + (grad_t'(sel_s1[1][0][8*k +: 8]) <<< 1)
					+ grad_t'(sel_s1[2][0][8*k +: 8]));
			end
			fe_s2 <= fe_s1;
		end
		if (state_q == S_SQ) begin
			for (int k = 0; k < 3; k++) begin
				sq_s3[k] <= SUM_W'($unsigned(22'(gx_s2[k] * gx_s2[k])))
					+ SUM_W'($unsigned(22'(gy_s2[k] * gy_s2[k])));
			end
			fe_s3 <= fe_s2;
		end
		if (out_load) begin
			out_red_q   <= root_mag[2];
			out_green_q <= root_mag[1];
			out_blue_q  <= root_mag[0];
			frame_end_q <= fe_s3;
		end
	end

	// one root unit per channel, started together
	for (genvar k = 0; k < 3; k++) begin : g_root
		sem_root u_root (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (root_start),
			.sum    (sq_s3[k]),
			.done   (root_done[k]),
			.mag    (root_mag[k])
		);
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign frame_end = frame_end_q;

	// root units finish only while the sequencer waits for them
	a_root_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done[0] |-> state_q == S_ROOT_WAIT)
		else $error("root finished outside wait state");

	// the three channel units stay in lockstep
	a_root_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		root_done[0] == root_done[1] && root_done[1] == root_done[2])
		else $error("channel root units out of step");

	// the memory stage follows only a transfer
	a_rd_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> $past(accept))
		else $error("memory stage entered without a transfer");

	// a new result appears only from the output state
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

endmodule

// ----- hdl/sem_root.sv -----
module sem_root (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sem_pkg::sum_t      sum,
	output logic               done,
	output logic [7:0]         mag
);
	import sem_pkg::*;

	sum_t        sum_q;
	logic [7:0]  root_q;
	logic [7:0]  bit_q;
	logic        busy_q;
	logic        rnd_q;
	logic        done_q;
	logic [7:0]  mag_q;

	logic [7:0]  trial;
	logic [15:0] trial_sq;
	logic [16:0] root_sq_plus;

	assign trial        = root_q | bit_q;
	assign trial_sq     = 16'(trial * trial);
	assign root_sq_plus = 17'(root_q * root_q) + 17'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per cycle, msb first, then rounding to nearest with saturation at 255
	always_ff @(posedge clk) begin
		if (start) begin
			sum_q  <= sum;
			root_q <= '0;
			bit_q  <= 8'h80;
		end else if (busy_q) begin
			if (SUM_W'(trial_sq) <= sum_q) begin
				root_q <= trial;
			end
			bit_q <= bit_q >> 1;
		end else if (rnd_q) begin
			if (sum_q > SAT_SUM) begin
				mag_q <= SAT_MAX;
			end else if (sum_q > SUM_W'(root_sq_plus)) begin
				mag_q <= root_q + 8'd1;
			end else begin
				mag_q <= root_q;
			end
		end
	end

	assign done = done_q;
	assign mag  = mag_q;

endmodule
